@@ rtl/permutation_rank_unrank_macros.svh @@
// Assertion macros shared by the permutation rank/unrank RTL
`ifndef PERMUTATION_RANK_UNRANK_MACROS_SVH
`define PERMUTATION_RANK_UNRANK_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define PRU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("pru: assertion failed");
// Check that an antecedent implies a consequent in the same cycle
`define PRU_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pru: implication failed");
`else
`define PRU_ASSERT(lbl, clk, rstn, prop)
`define PRU_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/pru_pkg.sv @@
// Package with widths, codes, stage bus type and helpers for the rank/unrank chain
`timescale 1ns / 1ps

package pru_pkg;

  localparam int unsigned MAX_ELEMS   = 8;
  localparam int unsigned SYM_W       = 3;
  localparam int unsigned PERM_W      = MAX_ELEMS * SYM_W;
  localparam int unsigned RANK_W      = 16;
  localparam int unsigned ELEMS_DEF   = 8;
  // Reciprocal shift: exact quotient for 16-bit dividends and divisors up to 8
  localparam int unsigned RECIP_SHIFT = 19;

  // Action codes
  localparam logic ACT_RANK   = 1'b0;
  localparam logic ACT_UNRANK = 1'b1;

  // Data handed from one cell to the next
  typedef struct packed {
    logic              valid;
    logic              action;
    logic [PERM_W-1:0] perm;   // permutation being ranked
    logic [RANK_W-1:0] acc;    // partial rank
    logic [RANK_W-1:0] num;    // remaining quotient being unranked
    logic [PERM_W-1:0] pool;   // unused symbols, ascending, packed low
    logic [PERM_W-1:0] pout;   // permutation built so far
  } pru_bus_t;

  // Falling factorial n * (n-1) * ... * (n-cnt+1)
  function automatic int unsigned falling(int unsigned n, int unsigned cnt);
    int unsigned p;
    p = 1;
    for (int unsigned k = 0; k < cnt; k++) begin
      p = p * (n - k);
    end
    return p;
  endfunction

  // Initial symbol pool 0..elems-1
  function automatic logic [PERM_W-1:0] pool_init(int unsigned elems);
    logic [PERM_W-1:0] p;
    p = '0;
    for (int unsigned k = 0; k < MAX_ELEMS; k++) begin
      if (k < elems) begin
        p[k*SYM_W +: SYM_W] = SYM_W'(k);
      end
    end
    return p;
  endfunction

endpackage

@@ rtl/pru_cell.sv @@
// One position cell of the rank/unrank chain: digit weight for rank, digit pick for unrank
`timescale 1ns / 1ps

module pru_cell #(
  parameter int unsigned ELEMS = pru_pkg::ELEMS_DEF,
  parameter int unsigned POS   = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pru_pkg::pru_bus_t bus_i,
  output pru_pkg::pru_bus_t bus_o
);
  import pru_pkg::*;

  localparam int unsigned RADIX  = ELEMS - POS;
  localparam int unsigned IDX_W  = $clog2(ELEMS);
  localparam int unsigned MULT_W = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W = RANK_W + MULT_W;
  localparam int unsigned MULT   = ((1 << RECIP_SHIFT) + RADIX - 1) / RADIX;
  localparam int unsigned WEIGHT = falling(ELEMS, POS);

  logic [SYM_W-1:0]  own_sym;
  logic [IDX_W-1:0]  cnt;
  logic [PROD_W-1:0] prod;
  pru_bus_t          a_d, a_q;
  logic [RANK_W-1:0] quot_d, quot_q;
  logic [RANK_W-1:0] rem_full;
  logic [IDX_W-1:0]  rem;
  logic [SYM_W-1:0]  pick;
  logic [PERM_W-1:0] pool_nx;
  pru_bus_t          b_d, b_q;

  // Stage A: count smaller later symbols, fold into rank, estimate quotient
  assign own_sym = bus_i.perm[POS*SYM_W +: SYM_W];

  always_comb begin
    cnt = '0;
    for (int unsigned j = POS + 1; j < ELEMS; j++) begin
      if (bus_i.perm[j*SYM_W +: SYM_W] < own_sym) begin
        cnt = cnt + IDX_W'(1);
      end
    end
  end

  assign prod   = PROD_W'(bus_i.num) * PROD_W'(MULT);
  assign quot_d = prod[RECIP_SHIFT +: RANK_W];

  always_comb begin
    a_d     = bus_i;
    a_d.acc = bus_i.acc + RANK_W'(cnt) * RANK_W'(WEIGHT);
  end

  // Stage B: recover digit, pick that unused symbol and close the pool gap
  assign rem_full = a_q.num - quot_q * RANK_W'(RADIX);
  assign rem      = rem_full[IDX_W-1:0];
  assign pick     = a_q.pool[rem*SYM_W +: SYM_W];

  always_comb begin
    pool_nx = '0;
    for (int unsigned k = 0; k < MAX_ELEMS; k++) begin
      if (k < int'(rem)) begin
        pool_nx[k*SYM_W +: SYM_W] = a_q.pool[k*SYM_W +: SYM_W];
      end else if (k + 1 < MAX_ELEMS) begin
        pool_nx[k*SYM_W +: SYM_W] = a_q.pool[(k+1)*SYM_W +: SYM_W];
      end
    end
  end

  always_comb begin
    b_d      = a_q;
    b_d.num  = quot_q;
    b_d.pool = pool_nx;
    b_d.pout = a_q.pout | (PERM_W'(pick) << (POS * SYM_W));
  end

  // Advance both stages every cycle; clear on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      quot_q <= '0;
      b_q    <= '0;
    end else begin
      a_q    <= a_d;
      quot_q <= quot_d;
      b_q    <= b_d;
    end
  end

  assign bus_o = b_q;

endmodule

@@ rtl/permutation_rank_unrank.sv @@
// Top level of the Lehmer-code rank/unrank chain for up to eight symbols
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------------
//   command  | in        | start, busy        | action_i, perm_in_i, rank_in_i
//   result   | out       | done_o (strobe)    | rank_out_o, perm_out_o
//
// A command transfers when start is high and busy is low; busy is never raised.
// Every command gives one result; one command per cycle. Each command passes
// through the row of ELEMS cells, each with two register stages
// (symbol count, rank fold and reciprocal multiply, then digit pick).
// Reset clears every stage of the chain; results cannot be stalled.
`timescale 1ns / 1ps
`include "permutation_rank_unrank_macros.svh"

module permutation_rank_unrank #(
  parameter int unsigned ELEMS = pru_pkg::ELEMS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       action_i,
  input  logic [pru_pkg::PERM_W-1:0] perm_in_i,
  input  logic [pru_pkg::RANK_W-1:0] rank_in_i,
  output logic                       done_o,
  output logic [pru_pkg::RANK_W-1:0] rank_out_o,
  output logic [pru_pkg::PERM_W-1:0] perm_out_o
);
  import pru_pkg::*;

  localparam int unsigned LAT  = 2 * ELEMS;
  localparam int unsigned FACT = falling(ELEMS, ELEMS);
  localparam logic [MAX_ELEMS-1:0] FULL = MAX_ELEMS'((1 << ELEMS) - 1);

  pru_bus_t             chain [ELEMS+1];
  pru_bus_t             last;
  logic [MAX_ELEMS-1:0] seen;

  // Never hold off commands
  assign busy = 1'b0;

  // Load the head of the chain on a command transfer
  always_comb begin
    chain[0].valid  = start & ~busy;
    chain[0].action = action_i;
    chain[0].perm   = perm_in_i;
    chain[0].acc    = '0;
    chain[0].num    = rank_in_i;
    chain[0].pool   = pool_init(ELEMS);
    chain[0].pout   = '0;
  end

  // Row of position cells
  for (genvar g = 0; g < ELEMS; g++) begin : g_cell
    pru_cell #(
      .ELEMS (ELEMS),
      .POS   (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .bus_i  (chain[g]),
      .bus_o  (chain[g+1])
    );
  end

  // Drive the result, zeroing the field the action does not produce
  assign last       = chain[ELEMS];
  assign done_o     = last.valid;
  assign rank_out_o = (last.action == ACT_RANK) ? last.acc : '0;
  assign perm_out_o = (last.action == ACT_UNRANK) ? last.pout : '0;

  // Mark symbols present in the unranked permutation
  always_comb begin
    seen = '0;
    for (int unsigned k = 0; k < ELEMS; k++) begin
      seen = seen | (MAX_ELEMS'(1) << last.pout[k*SYM_W +: SYM_W]);
    end
  end

  `PRU_ASSERT_IMPL(a_done_latency, clk_i, rst_ni, done_o, $past(start && !busy, LAT))
  `PRU_ASSERT_IMPL(a_rank_bound, clk_i, rst_ni, done_o, rank_out_o < RANK_W'(FACT))
  `PRU_ASSERT_IMPL(a_unrank_perm, clk_i, rst_ni, done_o && last.action == ACT_UNRANK, seen == FULL)

endmodule
